// File: rtl/core/itra_pkg.sv
package itra_pkg;

   localparam int NUMBER_W     = 32;
   localparam int RADIX_W      = 6;
   localparam int CHAR_W       = 8;
   localparam int STATUS_W     = 2;
   localparam int COUNT_W      = 6;
   localparam int DIGIT_W      = 6;
   localparam int DIGIT_SLOTS  = 32;

   // A non-negative 32-bit value needs one divide step per bit.
   localparam int DIV_STEPS    = 32;
   localparam int STEP_W       = $clog2(DIV_STEPS);

   localparam logic [RADIX_W-1:0] BASE_MIN      = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] BASE_MAX      = RADIX_W'(36);
   localparam logic [CHAR_W-1:0]  ASCII_ZERO    = CHAR_W'(48);
   localparam logic [CHAR_W-1:0]  ASCII_LOWER_A = CHAR_W'(97);
   localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = DIGIT_W'(10);

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_BAD_BASE = 2'd1,
      ST_NEGATIVE = 2'd2
   } status_type;

   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] wide_d;
      wide_d = {{(CHAR_W-DIGIT_W){1'b0}}, d};
      if (d < DECIMAL_LIMIT) begin
         return ASCII_ZERO + wide_d;
      end
      return ASCII_LOWER_A + wide_d - {{(CHAR_W-DIGIT_W){1'b0}}, DECIMAL_LIMIT};
   endfunction

endpackage

// File: rtl/core/itra_if.sv
interface itra_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [itra_pkg::NUMBER_W-1:0] number;
   logic [itra_pkg::RADIX_W-1:0]        radix;

   modport source (output valid, number, radix, input ready);
   modport sink   (input valid, number, radix, output ready);
endinterface

interface itra_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [itra_pkg::CHAR_W-1:0]   digit_char;
   logic                          is_last;
   logic [itra_pkg::STATUS_W-1:0] status;
   logic [itra_pkg::COUNT_W-1:0]  digit_count;

   modport source (output valid, digit_char, is_last, status, digit_count, input ready);
   modport sink   (input valid, digit_char, is_last, status, digit_count, output ready);
endinterface

// File: rtl/core/integer_to_radix_ascii.sv
// Converts a signed 32-bit value into lower-case ASCII digits in a base from 2 to 36.
// The request channel carries number and radix; it is ready only while the block is
// idle, so one item is converted at a time. The response channel gives one item per
// digit, most significant first, with is_last on the final digit and digit_count set
// to the total number of digits. A radix outside 2 to 36, or a negative number, gives
// a single response with is_last set, digit_char and digit_count zero and the status
// code naming the fault; the base test is made first.
// Each digit is found by one shared restoring divider that retires one quotient bit a
// cycle; the remainders go into a small digit memory. Emission then reads that memory
// back, each digit passing through read, convert and present steps in turn, and an
// error response is presented in the cycle after the request is taken.
// While a response is stalled it holds its fields and the block waits in place.
// Reset is synchronous and returns the block to idle with no response pending.
module integer_to_radix_ascii #(
   parameter int DIGIT_SLOTS = itra_pkg::DIGIT_SLOTS
) (
   input  logic       clock,
   input  logic       reset,
   itra_req_if.sink   req_if,
   itra_rsp_if.source rsp_if
);

   localparam int SLOT_W = $clog2(DIGIT_SLOTS);
   localparam int CNT_W  = $clog2(DIGIT_SLOTS + 1);
   localparam int DW     = itra_pkg::DIGIT_W;
   localparam int NW     = itra_pkg::NUMBER_W;
   localparam int SW     = itra_pkg::STEP_W;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_DIV   = 5'b00010,
      S_FETCH = 5'b00100,
      S_CONV  = 5'b01000,
      S_EMIT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [NW-1:0]     quo_ff, quo_in;
   logic [DW-1:0]     rem_ff, rem_in;
   logic [DW-1:0]     radix_ff, radix_in;
   logic [SW-1:0]     step_ff, step_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;

   logic [itra_pkg::CHAR_W-1:0]   char_ff, char_in;
   logic                          last_ff, last_in;
   logic [itra_pkg::STATUS_W-1:0] status_ff, status_in;

   logic [DW-1:0]     digit_store_ff [DIGIT_SLOTS];
   logic [DW-1:0]     rd_data_ff;
   logic              wr_en;
   logic [DW:0]       trial;
   logic [DW:0]       diff;
   logic              fits;
   logic [DW-1:0]     rem_step;
   logic [NW-1:0]     quo_step;
   logic              base_ok;

   // One restoring divide step: bring down the next dividend bit and subtract if it fits.
   always_comb begin
      trial    = {rem_ff, quo_ff[NW-1]};
      fits     = trial >= {1'b0, radix_ff};
      diff     = trial - {1'b0, radix_ff};
      rem_step = fits ? diff[DW-1:0] : trial[DW-1:0];
      quo_step = {quo_ff[NW-2:0], fits};
      base_ok  = req_if.radix inside {[itra_pkg::BASE_MIN:itra_pkg::BASE_MAX]};
   end

   always_comb begin
      state_in  = state_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      radix_in  = radix_ff;
      step_in   = step_ff;
      count_in  = count_ff;
      slot_in   = slot_ff;
      char_in   = char_ff;
      last_in   = last_ff;
      status_in = status_ff;
      wr_en     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               char_in  = '0;
               last_in  = 1'b1;
               count_in = '0;
               if (!base_ok) begin
                  status_in = itra_pkg::ST_BAD_BASE;
                  state_in  = S_EMIT;
               end else if (req_if.number[NW-1]) begin
                  status_in = itra_pkg::ST_NEGATIVE;
                  state_in  = S_EMIT;
               end else begin
                  status_in = itra_pkg::ST_OK;
                  quo_in    = req_if.number;
                  rem_in    = '0;
                  radix_in  = req_if.radix;
                  step_in   = '0;
                  state_in  = S_DIV;
               end
            end
         end
         S_DIV: begin
            quo_in  = quo_step;
            rem_in  = rem_step;
            step_in = step_ff + SW'(1);
            if (step_ff == SW'(itra_pkg::DIV_STEPS - 1)) begin
               // The remainder is complete: store it and start on the quotient.
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
               slot_in  = count_ff[SLOT_W-1:0];
               rem_in   = '0;
               if (quo_step == '0) begin
                  state_in = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            state_in = S_CONV;
         end
         S_CONV: begin
            char_in  = itra_pkg::digit_to_ascii(rd_data_ff);
            last_in  = (slot_ff == '0);
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_if.ready) begin
               if (last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  slot_in  = slot_ff - SLOT_W'(1);
                  state_in = S_FETCH;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      radix_ff  <= radix_in;
      step_ff   <= step_in;
      slot_ff   <= slot_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
      status_ff <= status_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         digit_store_ff[count_ff[SLOT_W-1:0]] <= rem_step;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= digit_store_ff[slot_ff];
   end

   assign req_if.ready       = (state_ff == S_IDLE);
   assign rsp_if.valid       = (state_ff == S_EMIT);
   assign rsp_if.digit_char  = char_ff;
   assign rsp_if.is_last     = last_ff;
   assign rsp_if.status      = status_ff;
   assign rsp_if.digit_count = itra_pkg::COUNT_W'(count_ff);

endmodule

// File: dv/integer_to_radix_ascii_tb.sv
`timescale 1ns / 100ps

module integer_to_radix_ascii_tb;

   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_PER_MODE = 25;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct {
      logic signed [itra_pkg::NUMBER_W-1:0] number;
      logic [itra_pkg::RADIX_W-1:0]         radix;
   } conversion_type;

   typedef struct {
      logic [itra_pkg::CHAR_W-1:0]  digit_char;
      logic                         is_last;
      itra_pkg::status_type         status;
      logic [itra_pkg::COUNT_W-1:0] digit_count;
   } digit_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   itra_req_if req_ch ();
   itra_rsp_if rsp_ch ();

   integer_to_radix_ascii dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always #6 clock = ~clock;

   conversion_type conversions_to_send[$];
   digit_rsp_type  expected_digits[$];
   idle_mode_type  idle_mode     = IDLE_NONE;
   logic           want_holdoff  = 1'b0;
   logic           holdoff_done  = 1'b0;
   int             hold_count    = 0;
   int             mismatches    = 0;
   int             idle_cycles   = 0;

   // Works out the digit items that one accepted conversion must produce.
   function automatic void predict_digits(
      input logic signed [itra_pkg::NUMBER_W-1:0] number,
      input logic [itra_pkg::RADIX_W-1:0] radix);
      logic [itra_pkg::NUMBER_W-1:0] value;
      logic [itra_pkg::NUMBER_W-1:0] base;
      logic [itra_pkg::DIGIT_W-1:0]  remainders[$];
      logic [itra_pkg::DIGIT_W-1:0]  r;
      digit_rsp_type                 d;
      int                            k;
      d.digit_char  = '0;
      d.is_last     = 1'b1;
      d.digit_count = '0;
      if (radix < itra_pkg::BASE_MIN || radix > itra_pkg::BASE_MAX) begin
         d.status = itra_pkg::ST_BAD_BASE;
         expected_digits.push_back(d);
      end else if (number < 0) begin
         d.status = itra_pkg::ST_NEGATIVE;
         expected_digits.push_back(d);
      end else begin
         value = number;
         base  = itra_pkg::NUMBER_W'(radix);
         do begin
            remainders.push_back(itra_pkg::DIGIT_W'(value % base));
            value = value / base;
         end while (value != 0);
         for (k = remainders.size() - 1; k >= 0; k--) begin
            r = remainders[k];
            if (r < itra_pkg::DECIMAL_LIMIT) begin
               d.digit_char = itra_pkg::ASCII_ZERO + itra_pkg::CHAR_W'(r);
            end else begin
               d.digit_char = itra_pkg::ASCII_LOWER_A + itra_pkg::CHAR_W'(r)
                              - itra_pkg::CHAR_W'(itra_pkg::DECIMAL_LIMIT);
            end
            d.is_last     = (k == 0);
            d.status      = itra_pkg::ST_OK;
            d.digit_count = itra_pkg::COUNT_W'(remainders.size());
            expected_digits.push_back(d);
         end
      end
   endfunction

   function automatic logic sender_idles();
      case (idle_mode)
         IDLE_SENDER: return $urandom_range(99) < 77;
         IDLE_BOTH:   return $urandom_range(99) < 22;
         default:     return 1'b0;
      endcase
   endfunction

   function automatic logic receiver_stalls();
      case (idle_mode)
         IDLE_RECEIVER: return $urandom_range(99) < 77;
         IDLE_BOTH:     return $urandom_range(99) < 22;
         default:       return 1'b0;
      endcase
   endfunction

   // Request driver: predicts on acceptance, then offers the next item or idles.
   always @(posedge clock) begin
      conversion_type c;
      if (reset) begin
         req_ch.valid  <= 1'b0;
         req_ch.number <= '0;
         req_ch.radix  <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_digits(req_ch.number, req_ch.radix);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (conversions_to_send.size() != 0 && !sender_idles()) begin
               c = conversions_to_send.pop_front();
               req_ch.valid  <= 1'b1;
               req_ch.number <= c.number;
               req_ch.radix  <= c.radix;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each accepted digit item and drives ready.
   always @(posedge clock) begin
      digit_rsp_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_digits.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected item: char %h last %b status %0d count %0d",
                        $time, rsp_ch.digit_char, rsp_ch.is_last, rsp_ch.status,
                        rsp_ch.digit_count);
            end else begin
               want = expected_digits.pop_front();
               if (rsp_ch.digit_char !== want.digit_char || rsp_ch.is_last !== want.is_last
                   || rsp_ch.status !== want.status
                   || rsp_ch.digit_count !== want.digit_count) begin
                  mismatches++;
                  $display("%0t: mismatch: expected char %h last %b status %0d count %0d",
                           $time, want.digit_char, want.is_last, want.status,
                           want.digit_count);
                  $display("%0t:           actual   char %h last %b status %0d count %0d",
                           $time, rsp_ch.digit_char, rsp_ch.is_last, rsp_ch.status,
                           rsp_ch.digit_count);
               end
            end
         end
         // A single long hold-off stalls the receiver while requests wait for the block to go idle.
         if (hold_count != 0) begin
            hold_count   <= hold_count - 1;
            rsp_ch.ready <= 1'b0;
         end else if (want_holdoff && !holdoff_done && rsp_ch.valid) begin
            hold_count   <= HOLD_CYCLES;
            holdoff_done <= 1'b1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= !receiver_stalls();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("** integer_to_radix_ascii: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic add_conversion(input int number, input int radix);
      conversion_type c;
      c.number = number;
      c.radix  = itra_pkg::RADIX_W'(radix);
      conversions_to_send.push_back(c);
   endtask

   task automatic add_random_conversions(input int count);
      int                            i;
      int unsigned                   pick;
      logic [itra_pkg::NUMBER_W-1:0] value;
      logic [itra_pkg::RADIX_W-1:0]  radix;
      for (i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         // Mostly well-formed conversions, with sizes from tiny to full width.
         value = $urandom() >> $urandom_range(31, 1);
         radix = itra_pkg::RADIX_W'($urandom_range(36, 2));
         if (pick < 12) begin
            radix = $urandom_range(1) ? itra_pkg::RADIX_W'($urandom_range(1, 0))
                                      : itra_pkg::RADIX_W'($urandom_range(63, 37));
            value = $urandom();
         end else if (pick < 25) begin
            value = $urandom() | 32'h8000_0000;
         end else if (pick < 30) begin
            value = '0;
         end
         add_conversion(int'(value), int'(radix));
      end
   endtask

   task automatic wait_until_drained();
      while (conversions_to_send.size() != 0 || req_ch.valid || expected_digits.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Zero in several bases, the largest value, and digits at the letter boundary.
      add_conversion(0, 10);
      add_conversion(0, 2);
      add_conversion(0, 36);
      add_conversion(1, 2);
      add_conversion(32'h7fff_ffff, 2);
      add_conversion(32'h7fff_ffff, 36);
      add_conversion(32'h7fff_ffff, 10);
      add_conversion(9, 10);
      add_conversion(10, 16);
      add_conversion(35, 36);
      add_conversion(36, 36);
      add_conversion(255, 16);
      // Negative values, bad bases, and a bad base on a negative value.
      add_conversion(-1, 10);
      add_conversion(32'h8000_0000, 16);
      add_conversion(5, 0);
      add_conversion(5, 1);
      add_conversion(5, 37);
      add_conversion(5, 63);
      add_conversion(-1, 63);
      wait_until_drained();

      want_holdoff <= 1'b1;
      add_random_conversions(RANDOM_PER_MODE);
      wait_until_drained();

      idle_mode <= IDLE_SENDER;
      add_random_conversions(RANDOM_PER_MODE);
      wait_until_drained();

      idle_mode <= IDLE_RECEIVER;
      add_random_conversions(RANDOM_PER_MODE);
      wait_until_drained();

      idle_mode <= IDLE_BOTH;
      add_random_conversions(RANDOM_PER_MODE);
      wait_until_drained();

      repeat (40) @(negedge clock);
      if (mismatches == 0) begin
         $display("** integer_to_radix_ascii: PASSED **");
      end else begin
         $display("** integer_to_radix_ascii: FAILED **");
      end
      $finish;
   end

endmodule
